### design/offset_to_line_column_translator_assert.svh
// Assertion macros used by the checker file of the translator.
`ifndef OFFSET_TO_LINE_COLUMN_TRANSLATOR_ASSERT_SVH
`define OFFSET_TO_LINE_COLUMN_TRANSLATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OLCT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("olct: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define OLCT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("olct: next-cycle check failed");

`endif

### design/olct_pkg.sv
package olct_pkg;

	localparam int MAX_LINES    = 256;
	localparam int OFFSET_WIDTH = 16;

	localparam int IDX_W   = $clog2(MAX_LINES);
	localparam int CNT_W   = 9;
	localparam int OFS_W   = OFFSET_WIDTH;
	localparam int LEN_W   = 16;
	localparam int LINE_W  = 8;
	localparam int COL_W   = 18;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LENGTH = 1'b1;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic [OFS_W-1:0] start;
		logic [OFS_W-1:0] trim;
		logic [OFS_W-1:0] column;
	} entry_t;

endpackage

### design/olct_ram.sv
module olct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/offset_to_line_column_translator.sv
// Offset to line/column translator.
// Input channel (in_valid/in_stall) takes load and query items. A load writes
// one line entry (start offset, trimmed whitespace, start column) into the
// entry RAM and gives no result. A query maps the range [query_start,
// query_end) onto line/column positions, the number of lines it crosses and
// the range widened to whole lines; it gives one result on the output
// channel (out_valid/out_stall).
// A query runs two binary searches over the line starts, interleaved on the
// single read port of the entry RAM: while one search issues its probe, the
// probe of the other is folded in. Three more RAM reads, the column state
// and the output state follow. The next item is taken in the cycle after the
// result enters the output register, even if the receiver still stalls it,
// so no new query is taken before the last result is in that register; a
// second result waits in the block until that register drains. in_stall is
// high while a query is in progress.
// Reset clears the registers and the control state; the entry RAM is not
// cleared, entries must be loaded before they are queried.
module offset_to_line_column_translator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [olct_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [olct_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              operation,
	input  logic [olct_pkg::IDX_W-1:0]        entry_index,
	input  logic [olct_pkg::OFS_W-1:0]        entry_start,
	input  logic [olct_pkg::OFS_W-1:0]        entry_trim,
	input  logic [olct_pkg::OFS_W-1:0]        entry_column,
	input  logic [olct_pkg::OFS_W-1:0]        query_start,
	input  logic [olct_pkg::OFS_W-1:0]        query_end,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [olct_pkg::LINE_W-1:0]       first_line,
	output logic [olct_pkg::COL_W-1:0]        start_column,
	output logic [olct_pkg::LINE_W-1:0]       last_line,
	output logic [olct_pkg::COL_W-1:0]        end_column,
	output logic [olct_pkg::LINE_W-1:0]       lines_spanned,
	output logic [olct_pkg::LEN_W-1:0]        full_start,
	output logic [olct_pkg::LEN_W-1:0]        full_end
);

	import olct_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_RD_A,
		ST_RD_B,
		ST_RD_N,
		ST_COL,
		ST_OUT
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0] num_lines_q;
	logic [LEN_W-1:0] total_length_q;

	logic [OFS_W-1:0] qs_q;
	logic [OFS_W-1:0] qe_q;

	// Search context 0 locates the start offset, context 1 the end offset.
	logic [CNT_W-1:0] lo_q [2];
	logic [CNT_W-1:0] hi_q [2];
	logic             ph_q;
	logic             pend_q;
	logic             pend_ctx_q;
	logic [IDX_W-1:0] pend_mid_q;

	logic [IDX_W-1:0] a_q;
	logic [IDX_W-1:0] b_q;
	entry_t           ent_a_q;
	entry_t           ent_b_q;
	logic [OFS_W-1:0] next_start_q;
	logic [COL_W-1:0] sc_q;
	logic [COL_W-1:0] ec_q;

	logic             out_valid_q;
	logic [LINE_W-1:0] first_line_q;
	logic [COL_W-1:0]  start_column_q;
	logic [LINE_W-1:0] last_line_q;
	logic [COL_W-1:0]  end_column_q;
	logic [LINE_W-1:0] lines_spanned_q;
	logic [LEN_W-1:0]  full_start_q;
	logic [LEN_W-1:0]  full_end_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_raddr;
	entry_t           ram_wdata;
	entry_t           ram_rdata;

	logic [CNT_W-1:0] lc_eff;
	logic             lc_zero;
	logic [CNT_W:0]   mid_sum;
	logic [CNT_W-1:0] mid_full;
	logic             probe_go;
	logic             search_done;
	logic [OFS_W-1:0] pend_ofs;
	logic             probe_le;
	logic [IDX_W-1:0] idx_a;
	logic [IDX_W-1:0] idx_b;
	logic             in_accept;
	logic             out_free;
	logic             out_load;

	logic [OFS_W-1:0] within_s;
	logic [OFS_W-1:0] within_e;
	logic [COL_W-1:0] sc_calc;
	logic [COL_W-1:0] ec_calc;

	logic              next_ok;
	logic              collapse;
	logic              qe_over;
	logic [LINE_W-1:0] nxt_sl;
	logic [COL_W-1:0]  nxt_sc;
	logic [LINE_W-1:0] nxt_el;
	logic [COL_W-1:0]  nxt_ec;
	logic [LINE_W-1:0] nxt_span;
	logic [LEN_W-1:0]  nxt_fs;
	logic [LEN_W-1:0]  nxt_fe;

	olct_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_LINES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (entry_index),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = (state_q == ST_OUT) && out_free;

	assign ram_we           = in_accept && (operation == OP_LOAD);
	assign ram_wdata.start  = entry_start;
	assign ram_wdata.trim   = entry_trim;
	assign ram_wdata.column = entry_column;

	assign lc_eff  = (num_lines_q > CNT_W'(MAX_LINES)) ? CNT_W'(MAX_LINES) : num_lines_q;
	assign lc_zero = (lc_eff == '0);

	// Probe of the context whose turn it is.
	assign mid_sum     = {1'b0, lo_q[ph_q]} + {1'b0, hi_q[ph_q]};
	assign mid_full    = mid_sum[CNT_W:1];
	assign probe_go    = (lo_q[ph_q] < hi_q[ph_q]);
	assign search_done = !pend_q && (lo_q[0] == hi_q[0]) && (lo_q[1] == hi_q[1]);
	assign pend_ofs    = pend_ctx_q ? qe_q : qs_q;
	assign probe_le    = (ram_rdata.start <= pend_ofs);

	// Last entry at or below the offset, entry 0 if none.
	assign idx_a = (lo_q[0] == '0) ? '0 : IDX_W'(lo_q[0] - CNT_W'(1));
	assign idx_b = (lo_q[1] == '0) ? '0 : IDX_W'(lo_q[1] - CNT_W'(1));

	always_comb begin
		ram_raddr = '0;
		unique case (state_q)
			ST_SEARCH: ram_raddr = mid_full[IDX_W-1:0];
			ST_RD_A:   ram_raddr = idx_a;
			ST_RD_B:   ram_raddr = idx_b;
			ST_RD_N:   ram_raddr = b_q + IDX_W'(1);
			default:   ram_raddr = '0;
		endcase
	end

	// Offset within the line saturates at zero before the line start.
	assign within_s = (qs_q >= ent_a_q.start) ? (qs_q - ent_a_q.start) : '0;
	assign within_e = (qe_q >= ent_b_q.start) ? (qe_q - ent_b_q.start) : '0;
	assign sc_calc  = COL_W'(ent_a_q.column) + COL_W'(within_s) + COL_W'(ent_a_q.trim);
	// Left preference: drop the trim when the end sits on or before the line start.
	assign ec_calc  = COL_W'(ent_b_q.column) + COL_W'(within_e)
		+ ((within_e == '0) ? COL_W'(0) : COL_W'(ent_b_q.trim));

	always_comb begin
		qe_over  = (qe_q > total_length_q);
		next_ok  = ((CNT_W'(b_q) + CNT_W'(1)) < lc_eff);
		collapse = (b_q < a_q) || ((b_q == a_q) && (ec_q < sc_q));
		if (lc_zero) begin
			nxt_sl   = '0;
			nxt_sc   = '0;
			nxt_el   = '0;
			nxt_ec   = '0;
			nxt_span = '0;
			nxt_fs   = '0;
			nxt_fe   = total_length_q;
		end else begin
			nxt_el   = LINE_W'(b_q);
			nxt_ec   = ec_q;
			nxt_sl   = collapse ? LINE_W'(b_q) : LINE_W'(a_q);
			nxt_sc   = collapse ? ec_q : sc_q;
			nxt_span = ((qs_q < qe_q) && !qe_over && (b_q > a_q))
				? LINE_W'(b_q - a_q) : '0;
			nxt_fs   = (ent_a_q.start <= qs_q) ? LEN_W'(ent_a_q.start) : '0;
			priority if (ent_b_q.start >= qe_q) begin
				nxt_fe = LEN_W'(ent_b_q.start);
			end else if (next_ok) begin
				nxt_fe = LEN_W'(next_start_q);
			end else begin
				nxt_fe = total_length_q;
			end
		end
		if (qe_over) begin
			nxt_fs = '0;
			nxt_fe = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_lines_q    <= '0;
			total_length_q <= '0;
		end else if (cfg_write) begin
			if (cfg_index == CFG_LINE_COUNT) begin
				num_lines_q <= cfg_data[CNT_W-1:0];
			end else begin
				total_length_q <= cfg_data[LEN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			qs_q            <= '0;
			qe_q            <= '0;
			lo_q[0]         <= '0;
			lo_q[1]         <= '0;
			hi_q[0]         <= '0;
			hi_q[1]         <= '0;
			ph_q            <= 1'b0;
			pend_q          <= 1'b0;
			pend_ctx_q      <= 1'b0;
			pend_mid_q      <= '0;
			a_q             <= '0;
			b_q             <= '0;
			ent_a_q         <= '0;
			ent_b_q         <= '0;
			next_start_q    <= '0;
			sc_q            <= '0;
			ec_q            <= '0;
			out_valid_q     <= 1'b0;
			first_line_q    <= '0;
			start_column_q  <= '0;
			last_line_q     <= '0;
			end_column_q    <= '0;
			lines_spanned_q <= '0;
			full_start_q    <= '0;
			full_end_q      <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept && (operation == OP_QUERY)) begin
						qs_q    <= query_start;
						qe_q    <= query_end;
						lo_q[0] <= '0;
						lo_q[1] <= '0;
						hi_q[0] <= lc_eff;
						hi_q[1] <= lc_eff;
						ph_q    <= 1'b0;
						pend_q  <= 1'b0;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					// Fold in the probe issued last cycle, then issue the other context.
					if (pend_q) begin
						if (probe_le) begin
							lo_q[pend_ctx_q] <= CNT_W'(pend_mid_q) + CNT_W'(1);
						end else begin
							hi_q[pend_ctx_q] <= CNT_W'(pend_mid_q);
						end
					end
					pend_q     <= probe_go;
					pend_ctx_q <= ph_q;
					pend_mid_q <= mid_full[IDX_W-1:0];
					ph_q       <= ~ph_q;
					if (search_done) begin
						state_q <= ST_RD_A;
					end
				end
				ST_RD_A: begin
					a_q     <= idx_a;
					state_q <= ST_RD_B;
				end
				ST_RD_B: begin
					b_q     <= idx_b;
					ent_a_q <= ram_rdata;
					state_q <= ST_RD_N;
				end
				ST_RD_N: begin
					ent_b_q <= ram_rdata;
					state_q <= ST_COL;
				end
				ST_COL: begin
					next_start_q <= ram_rdata.start;
					sc_q         <= sc_calc;
					ec_q         <= ec_calc;
					state_q      <= ST_OUT;
				end
				ST_OUT: begin
					// Hold here until the output register is free.
					if (out_free) begin
						first_line_q    <= nxt_sl;
						start_column_q  <= nxt_sc;
						last_line_q     <= nxt_el;
						end_column_q    <= nxt_ec;
						lines_spanned_q <= nxt_span;
						full_start_q    <= nxt_fs;
						full_end_q      <= nxt_fe;
						state_q         <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign first_line    = first_line_q;
	assign start_column  = start_column_q;
	assign last_line     = last_line_q;
	assign end_column    = end_column_q;
	assign lines_spanned = lines_spanned_q;
	assign full_start    = full_start_q;
	assign full_end      = full_end_q;

endmodule

### design/olct_checker.sv
`include "offset_to_line_column_translator_assert.svh"

module olct_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [olct_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [olct_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              operation,
	input  logic [olct_pkg::IDX_W-1:0]        entry_index,
	input  logic [olct_pkg::OFS_W-1:0]        entry_start,
	input  logic [olct_pkg::OFS_W-1:0]        entry_trim,
	input  logic [olct_pkg::OFS_W-1:0]        entry_column,
	input  logic [olct_pkg::OFS_W-1:0]        query_start,
	input  logic [olct_pkg::OFS_W-1:0]        query_end,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [olct_pkg::LINE_W-1:0]       first_line,
	input  logic [olct_pkg::COL_W-1:0]        start_column,
	input  logic [olct_pkg::LINE_W-1:0]       last_line,
	input  logic [olct_pkg::COL_W-1:0]        end_column,
	input  logic [olct_pkg::LINE_W-1:0]       lines_spanned,
	input  logic [olct_pkg::LEN_W-1:0]        full_start,
	input  logic [olct_pkg::LEN_W-1:0]        full_end
);

	import olct_pkg::*;

	// A stalled result holds.
	`OLCT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(first_line) && $stable(start_column) && $stable(last_line) && $stable(end_column) && $stable(full_end))

	// A query keeps the input side busy; a load leaves it free.
	`OLCT_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && (operation == OP_QUERY), in_stall)
	`OLCT_ASSERT_NEXT(a_load_free, in_valid && !in_stall && (operation == OP_LOAD), !in_stall)

	// The start position never lies after the end position.
	`OLCT_ASSERT_NOW(a_start_before_end, out_valid, (first_line < last_line) || ((first_line == last_line) && (start_column <= end_column)))

	// A nonzero span is the distance between the reported lines.
	`OLCT_ASSERT_NOW(a_span_matches, out_valid && (lines_spanned != '0), lines_spanned == LINE_W'(last_line - first_line))

endmodule

bind offset_to_line_column_translator olct_checker u_olct_checker (.*);

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import olct_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 1_200_000;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned PHASE_ITEMS   = 150;
	localparam int unsigned PHASES        = 10;

	typedef struct packed {
		logic [LINE_W-1:0] first_line;
		logic [COL_W-1:0]  start_column;
		logic [LINE_W-1:0] last_line;
		logic [COL_W-1:0]  end_column;
		logic [LINE_W-1:0] lines_spanned;
		logic [LEN_W-1:0]  full_start;
		logic [LEN_W-1:0]  full_end;
	} position_t;

	typedef struct packed {
		logic             op;
		logic [IDX_W-1:0] index;
		logic [OFS_W-1:0] first_ofs;
		logic [OFS_W-1:0] trim;
		logic [OFS_W-1:0] column;
		logic [OFS_W-1:0] qstart;
		logic [OFS_W-1:0] qend;
	} item_t;

	typedef enum logic {ROW_WRITE, ROW_SEND} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] reg_data;
		item_t                 it;
		bit                    pinned;
		logic [LEN_W-1:0]      pinned_end;
	} step_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_write   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic                  operation   = OP_LOAD;
	logic [IDX_W-1:0]      entry_index = '0;
	logic [OFS_W-1:0]      entry_start = '0;
	logic [OFS_W-1:0]      entry_trim  = '0;
	logic [OFS_W-1:0]      entry_column = '0;
	logic [OFS_W-1:0]      query_start = '0;
	logic [OFS_W-1:0]      query_end   = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [LINE_W-1:0]     first_line;
	logic [COL_W-1:0]      start_column;
	logic [LINE_W-1:0]     last_line;
	logic [COL_W-1:0]      end_column;
	logic [LINE_W-1:0]     lines_spanned;
	logic [LEN_W-1:0]      full_start;
	logic [LEN_W-1:0]      full_end;

	offset_to_line_column_translator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.entry_index(entry_index),
		.entry_start(entry_start),
		.entry_trim(entry_trim),
		.entry_column(entry_column),
		.query_start(query_start),
		.query_end(query_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.first_line(first_line),
		.start_column(start_column),
		.last_line(last_line),
		.end_column(end_column),
		.lines_spanned(lines_spanned),
		.full_start(full_start),
		.full_end(full_end)
	);

	// shadow copy of the line table and registers
	logic [OFS_W-1:0] line_first [MAX_LINES];
	logic [OFS_W-1:0] line_trim  [MAX_LINES];
	logic [OFS_W-1:0] line_col   [MAX_LINES];
	logic [CNT_W-1:0] held_lines  = '0;
	logic [LEN_W-1:0] held_length = '0;

	position_t   due_results [$];
	position_t   popped;
	step_t       plan [$];
	int unsigned cycle_count = 0;
	int unsigned mismatches  = 0;
	int unsigned loads_done  = 0;
	int unsigned queries_done = 0;
	int unsigned stall_left  = 0;
	bit          tx_calm     = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	function automatic int unsigned pick_gap(input bit calm);
		int unsigned k;
		k = $urandom_range(0, 99);
		if (calm || k < 60)
			return 0;
		if (k < 85)
			return $urandom_range(1, 3);
		if (k < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int unsigned active_lines();
		return (held_lines > CNT_W'(MAX_LINES)) ? MAX_LINES : int'(held_lines);
	endfunction

	// last entry at or below ofs among the first n, else entry 0
	function automatic int unsigned line_holding(input logic [OFS_W-1:0] ofs,
			input int unsigned n);
		int unsigned lo, hi, mid;
		lo = 0;
		hi = n;
		while (lo < hi) begin
			mid = (lo + hi) >> 1;
			if (line_first[mid] <= ofs)
				lo = mid + 1;
			else
				hi = mid;
		end
		return (lo == 0) ? 0 : lo - 1;
	endfunction

	function automatic void place(input logic [OFS_W-1:0] ofs, input bit left_pref,
			output logic [LINE_W-1:0] line, output logic [COL_W-1:0] col);
		int unsigned n, i;
		logic [COL_W-1:0] ofs_in_line;
		n = active_lines();
		line = '0;
		col = '0;
		if (n != 0) begin
			i = line_holding(ofs, n);
			ofs_in_line = (ofs >= line_first[i]) ? COL_W'(ofs - line_first[i]) : '0;
			col = COL_W'(line_col[i]) + ofs_in_line;
			// a left-preferred offset sitting on or before the line start skips the trim
			if (!(ofs_in_line == 0 && left_pref))
				col = col + COL_W'(line_trim[i]);
			line = LINE_W'(i);
		end
	endfunction

	function automatic position_t translate(input logic [OFS_W-1:0] qs,
			input logic [OFS_W-1:0] qe);
		position_t r;
		logic [LINE_W-1:0] sl, el;
		logic [COL_W-1:0] sc, ec;
		int unsigned n, a, b, k;
		bit found;
		n = active_lines();
		place(qs, 1'b0, sl, sc);
		place(qe, 1'b1, el, ec);
		r.lines_spanned = '0;
		if (qs < qe && qe <= held_length && n != 0) begin
			a = line_holding(qs, n);
			b = line_holding(qe, n);
			if (b > a)
				r.lines_spanned = LINE_W'(b - a);
		end
		// collapse the start onto the end when the end lies before it
		if (el < sl || (el == sl && ec < sc)) begin
			sl = el;
			sc = ec;
		end
		r.first_line = sl;
		r.start_column = sc;
		r.last_line = el;
		r.end_column = ec;
		r.full_start = '0;
		r.full_end = '0;
		if (qe <= held_length) begin
			found = 1'b0;
			for (k = n; k > 0 && !found; k--) begin
				if (line_first[k-1] <= qs) begin
					r.full_start = line_first[k-1];
					found = 1'b1;
				end
			end
			r.full_end = held_length;
			found = 1'b0;
			for (k = 0; k < n && !found; k++) begin
				if (qe <= line_first[k]) begin
					r.full_end = line_first[k];
					found = 1'b1;
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0d] mismatch: %s", cycle_count, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [COL_W-1:0] got,
			input logic [COL_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				report_mismatch("result with no query waiting");
			end else begin
				popped = due_results.pop_front();
				check_field("first_line", first_line, popped.first_line);
				check_field("start_column", start_column, popped.start_column);
				check_field("last_line", last_line, popped.last_line);
				check_field("end_column", end_column, popped.end_column);
				check_field("lines_spanned", lines_spanned, popped.lines_spanned);
				check_field("full_start", full_start, popped.full_start);
				check_field("full_end", full_end, popped.full_end);
			end
		end
	end

	// receiver back-pressure, with recurring calm stretches
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left = stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			stall_left = ($urandom_range(0, 3) == 0) ?
				pick_gap(((cycle_count >> 11) % 4) == 3) : 0;
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left = stall_left - 1;
		end
	end

	task automatic send(input item_t it, input bit pinned, input logic [LEN_W-1:0] pinned_end);
		int unsigned gap;
		position_t want;
		gap = pick_gap(tx_calm);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= it.op;
		entry_index <= it.index;
		entry_start <= it.first_ofs;
		entry_trim <= it.trim;
		entry_column <= it.column;
		query_start <= it.qstart;
		query_end <= it.qend;
		do @(posedge clk); while (in_stall);
		if (it.op == OP_LOAD) begin
			line_first[it.index] = it.first_ofs;
			line_trim[it.index] = it.trim;
			line_col[it.index] = it.column;
			loads_done++;
		end else begin
			if (pinned) begin
				want = '0;
				want.full_end = pinned_end;
			end else begin
				want = translate(it.qstart, it.qend);
			end
			due_results.push_back(want);
			queries_done++;
		end
	endtask

	// hold the sender until every result has drained, then let loads finish
	task automatic settle();
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == CFG_LINE_COUNT)
			held_lines = data[CNT_W-1:0];
		else
			held_length = data;
		@(posedge clk);
	endtask

	function automatic item_t noise_item();
		item_t it;
		it.op = OP_QUERY;
		it.index = IDX_W'($urandom);
		it.first_ofs = OFS_W'($urandom);
		it.trim = OFS_W'($urandom);
		it.column = OFS_W'($urandom);
		it.qstart = OFS_W'($urandom);
		it.qend = OFS_W'($urandom);
		return it;
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
		step_t s;
		s.kind = ROW_WRITE;
		s.reg_index = idx;
		s.reg_data = CFG_DATA_W'(data);
		s.it = noise_item();
		s.pinned = 1'b0;
		s.pinned_end = '0;
		plan.push_back(s);
	endfunction

	function automatic void add_load(input int unsigned i, input int unsigned st,
			input int unsigned tr, input int unsigned col);
		step_t s;
		s.kind = ROW_SEND;
		s.reg_index = CFG_LINE_COUNT;
		s.reg_data = '0;
		s.it = noise_item();
		s.it.op = OP_LOAD;
		s.it.index = IDX_W'(i);
		s.it.first_ofs = OFS_W'(st);
		s.it.trim = OFS_W'(tr);
		s.it.column = OFS_W'(col);
		s.pinned = 1'b0;
		s.pinned_end = '0;
		plan.push_back(s);
	endfunction

	function automatic void add_query(input int unsigned qs, input int unsigned qe,
			input bit pinned, input int unsigned fe);
		step_t s;
		s.kind = ROW_SEND;
		s.reg_index = CFG_LINE_COUNT;
		s.reg_data = '0;
		s.it = noise_item();
		s.it.op = OP_QUERY;
		s.it.qstart = OFS_W'(qs);
		s.it.qend = OFS_W'(qe);
		s.pinned = pinned;
		s.pinned_end = LEN_W'(fe);
		plan.push_back(s);
	endfunction

	// sorted line starts, mostly from zero, with some repeated starts
	task automatic load_table(input int unsigned n);
		item_t it;
		int unsigned span, step_max, step, at, i;
		span = $urandom_range(0, 1) ? int'(held_length) : 65535;
		step_max = 2 * span / n + 1;
		at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, step_max) : 0;
		for (i = 0; i < n; i++) begin
			it = noise_item();
			it.op = OP_LOAD;
			it.index = IDX_W'(i);
			it.first_ofs = OFS_W'(at);
			send(it, 1'b0, '0);
			step = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, step_max);
			at = (at + step > 65535) ? 65535 : at + step;
		end
	endtask

	task automatic random_item();
		item_t it;
		int unsigned n, k, i, lo, hi, tl, on, qs, qe;
		it = noise_item();
		n = active_lines();
		tl = held_length;
		if ($urandom_range(0, 9) == 0) begin
			it.op = OP_LOAD;
			// rewrite an active entry without breaking the order of starts
			if (n != 0) begin
				i = $urandom_range(0, n - 1);
				lo = (i == 0) ? 0 : int'(line_first[i-1]);
				hi = (i == n - 1) ? 65535 : int'(line_first[i+1]);
				it.index = IDX_W'(i);
				it.first_ofs = OFS_W'($urandom_range(lo, hi));
			end
		end else begin
			it.op = OP_QUERY;
			k = $urandom_range(0, 99);
			if (k < 40) begin
				qs = $urandom_range(0, tl);
				qe = $urandom_range(qs, tl);
			end else if (k < 60 && n != 0) begin
				on = line_first[$urandom_range(0, n - 1)];
				if ($urandom_range(0, 1)) begin
					qs = on;
					qe = (on <= tl) ? $urandom_range(on, tl) : on;
				end else begin
					qe = on;
					qs = $urandom_range(0, on);
				end
			end else if (k < 85 && tl < 65535) begin
				qe = $urandom_range(tl + 1, 65535);
				qs = $urandom_range(0, 65535);
			end else if (k < 92) begin
				qe = $urandom_range(0, tl);
				qs = $urandom_range(qe, 65535);
			end else begin
				qs = $urandom_range(0, 65535);
				qe = $urandom_range(0, 65535);
			end
			it.qstart = OFS_W'(qs);
			it.qend = OFS_W'(qe);
		end
		send(it, 1'b0, '0);
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("run stopped at cycle %0d with %0d results due", cycle_count,
			due_results.size());
		$display("testbench NOT OK");
		$finish;
	end

	initial begin
		int unsigned ph, j, lc, tl, hold_at;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table straight after reset, then with the longest sequence
		add_query(0, 0, 1'b1, 0);
		add_query(65535, 65535, 1'b1, 0);
		add_query(0, 65535, 1'b1, 0);
		add_write(CFG_TOTAL_LENGTH, 65535);
		add_query(0, 65535, 1'b1, 65535);
		add_query(65535, 0, 1'b1, 65535);
		add_load(0, 0, 2, 4);
		add_load(1, 10, 0, 0);
		add_load(2, 10, 3, 1);
		add_load(3, 40, 65535, 65535);
		add_load(255, 65535, 65535, 65535);
		add_write(CFG_LINE_COUNT, 4);
		add_write(CFG_TOTAL_LENGTH, 60);
		add_query(0, 0, 1'b0, 0);
		add_query(5, 12, 1'b0, 0);
		add_query(10, 10, 1'b0, 0);
		add_query(12, 5, 1'b0, 0);
		add_query(40, 60, 1'b0, 0);
		add_query(0, 61, 1'b0, 0);
		add_query(65535, 65535, 1'b0, 0);
		add_query(45, 44, 1'b0, 0);
		// move entry 0 off zero so offsets can fall before the first line
		add_load(0, 5, 7, 9);
		add_query(2, 3, 1'b0, 0);
		add_query(0, 5, 1'b0, 0);

		foreach (plan[s]) begin
			if (plan[s].kind == ROW_WRITE) begin
				settle();
				write_reg(plan[s].reg_index, plan[s].reg_data);
			end else begin
				send(plan[s].it, plan[s].pinned, plan[s].pinned_end);
			end
		end

		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			unique case (ph)
				0: begin
					lc = 0;
					tl = $urandom_range(0, 65535);
				end
				1: begin
					lc = 1;
					tl = 0;
				end
				2: begin
					lc = MAX_LINES;
					tl = 65535;
				end
				3: begin
					// above the table size, reuses the full table as it stands
					lc = 511;
					tl = $urandom_range(0, 65535);
				end
				4: begin
					lc = 2;
					tl = $urandom_range(0, 65535);
				end
				default: begin
					lc = $urandom_range(3, 64);
					tl = $urandom_range(0, 65535);
				end
			endcase
			write_reg(CFG_LINE_COUNT, CFG_DATA_W'(lc));
			write_reg(CFG_TOTAL_LENGTH, CFG_DATA_W'(tl));
			tx_calm = (ph % 4 == 3);
			if (lc != 0 && lc <= MAX_LINES)
				load_table(active_lines());
			hold_at = $urandom_range(20, PHASE_ITEMS - 20);
			for (j = 0; j < PHASE_ITEMS; j++) begin
				if (j == hold_at)
					settle();
				random_item();
			end
		end
		settle();

		$display("sent %0d loads and %0d queries over %0d table settings plus the directed steps",
			loads_done, queries_done, PHASES);
		$display("line counts from empty to full and saturated, lengths from 0 to 65535");
		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

### filelist.f
+incdir+design
design/olct_pkg.sv
design/olct_ram.sv
design/offset_to_line_column_translator.sv
design/olct_checker.sv
tb/testbench.sv
